// ===== src/assert_macros.svh =====
// Assertion macros used by the RTL datapath.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons)

`define ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

// ===== src/bnms_pkg.sv =====
package bnms_pkg;

   localparam int BoxIndexWidth = 10;
   localparam int IndexFieldMax = 1023;
   localparam int ThresholdWidth = 9;
   localparam logic [ThresholdWidth-1:0] ThresholdReset = 9'd128;

   typedef struct packed {
      logic signed [15:0] box_left;
      logic signed [15:0] box_top;
      logic [14:0]        box_width;
      logic [14:0]        box_height;
      logic               last_box;
   } req_payload_type;

   typedef struct packed {
      logic                     keep;
      logic [BoxIndexWidth-1:0] box_index;
      logic                     store_overflow;
      logic                     frame_end;
   } rsp_payload_type;

   typedef struct packed {
      logic signed [15:0] left;
      logic signed [15:0] top;
      logic signed [16:0] right;
      logic signed [16:0] bottom;
      logic [29:0]        area;
   } kept_entry_type;

   typedef struct packed {
      logic capture;
      logic issue;
      logic finish;
   } dp_cmd_type;

   typedef struct packed {
      logic scan_done;
      logic pipe_busy;
      logic slot_free;
   } dp_status_type;

endpackage

// ===== src/box_nms_suppressor_unit.sv =====
// Each box is compared against every box kept so far in the frame; a stalled rsp_ready
// delays the next result. A new box is accepted only after the previous one has finished.
// The kept-box RAM is read one entry per cycle during the scan.
// The response register frees the input side while a result waits for rsp_ready.
// Reset: synchronous, active high; clears counters and loads threshold 128.
// Kept-box RAM is not cleared; only entries written in the current frame are read.
module box_nms_suppressor_unit import bnms_pkg::*; #(
   parameter int MAX_KEPT = 64,
   parameter int MAX_BOXES = 1024
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  req_payload_type           req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output rsp_payload_type           rsp_payload,
   input  logic                      csr_write_enable,
   input  logic [ThresholdWidth-1:0] csr_write_data
);

   dp_cmd_type    cmd;
   dp_status_type status;

   bnms_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .status   (status),
      .cmd      (cmd)
   );

   bnms_datapath #(
      .MAX_KEPT (MAX_KEPT),
      .MAX_BOXES(MAX_BOXES)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_payload     (req_payload),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_payload     (rsp_payload),
      .csr_write_enable(csr_write_enable),
      .csr_write_data  (csr_write_data)
   );

endmodule

// ===== src/bnms_ram.sv =====
module bnms_ram #(
   parameter int WIDTH = 96,
   parameter int DEPTH = 64,
   localparam int AddrWidth = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [AddrWidth-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic                 rd_en,
   input  logic [AddrWidth-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/bnms_ctrl.sv =====
module bnms_ctrl import bnms_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   typedef enum logic [1:0] {
      IDLE,
      SCAN,
      DRAIN,
      FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      req_ready_ff, req_ready_in;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      unique case (state_ff)
         IDLE: begin
            if (req_valid && req_ready_ff) begin
               cmd.capture = 1'b1;
               state_in = SCAN;
            end
         end
         SCAN: begin
            if (status.scan_done) begin
               state_in = DRAIN;
            end else begin
               cmd.issue = 1'b1;
            end
         end
         DRAIN: begin
            if (!status.pipe_busy) begin
               state_in = FINISH;
            end
         end
         FINISH: begin
            if (status.slot_free) begin
               cmd.finish = 1'b1;
               state_in = IDLE;
            end
         end
         default: state_in = IDLE;
      endcase
      req_ready_in = (state_in == IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         req_ready_ff <= 1'b1;
      end else begin
         state_ff <= state_in;
         req_ready_ff <= req_ready_in;
      end
   end

   assign req_ready = req_ready_ff;

endmodule

// ===== src/bnms_datapath.sv =====
`include "assert_macros.svh"

module bnms_datapath import bnms_pkg::*; #(
   parameter int MAX_KEPT = 64,
   parameter int MAX_BOXES = 1024
) (
   input  logic                      clock,
   input  logic                      reset,
   input  dp_cmd_type                cmd,
   output dp_status_type             status,
   input  req_payload_type           req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output rsp_payload_type           rsp_payload,
   input  logic                      csr_write_enable,
   input  logic [ThresholdWidth-1:0] csr_write_data
);

   localparam int AddrWidth = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
   localparam int CountWidth = $clog2(MAX_KEPT + 1);
   localparam int IndexLimit =
      ((MAX_BOXES - 1) > IndexFieldMax) ? IndexFieldMax : (MAX_BOXES - 1);
   localparam int PipeDepth = 5;

   function automatic logic [14:0] overlap(input logic signed [15:0] a0,
                                           input logic signed [16:0] a1,
                                           input logic signed [15:0] b0,
                                           input logic signed [16:0] b1);
      logic signed [15:0] lo;
      logic signed [16:0] hi;
      logic signed [17:0] diff;
      lo = (a0 > b0) ? a0 : b0;
      hi = (a1 < b1) ? a1 : b1;
      diff = 18'(hi) - 18'(lo);
      overlap = (hi > 17'(lo)) ? diff[14:0] : 15'd0;
   endfunction

   logic [ThresholdWidth-1:0] threshold_ff;
   kept_entry_type            box_ff, box_in;
   logic                      last_ff;
   logic [CountWidth-1:0]     kept_count_ff, kept_count_in;
   logic [BoxIndexWidth-1:0]  box_counter_ff, box_counter_in;
   logic [CountWidth-1:0]     rd_idx_ff;
   logic [PipeDepth-1:0]      valid_ff;
   logic                      keep_ff;
   logic                      rsp_valid_ff;
   rsp_payload_type           rsp_payload_ff, rsp_payload_in;

   kept_entry_type ram_q;
   logic           store_full;
   logic           store_wr;
   logic           hit;

   logic [14:0] iw_ff, ih_ff, iw_in, ih_in;
   logic [29:0] karea2_ff, karea3_ff, inter3_ff, inter4_ff, inter3_in;
   logic [30:0] uni4_ff, uni4_in;
   logic [39:0] prod5_ff, prod5_in;
   logic [37:0] lhs5_ff;

   assign box_in.left = req_payload.box_left;
   assign box_in.top = req_payload.box_top;
   assign box_in.right = 17'(req_payload.box_left) + $signed({2'b00, req_payload.box_width});
   assign box_in.bottom = 17'(req_payload.box_top) + $signed({2'b00, req_payload.box_height});
   assign box_in.area = 30'(req_payload.box_width) * 30'(req_payload.box_height);

   assign store_full = (kept_count_ff == CountWidth'(MAX_KEPT));
   assign store_wr = cmd.finish && keep_ff && !store_full;

   bnms_ram #(
      .WIDTH($bits(kept_entry_type)),
      .DEPTH(MAX_KEPT)
   ) u_kept_ram (
      .clock  (clock),
      .wr_en  (store_wr),
      .wr_addr(kept_count_ff[AddrWidth-1:0]),
      .wr_data(box_ff),
      .rd_en  (cmd.issue),
      .rd_addr(rd_idx_ff[AddrWidth-1:0]),
      .rd_data(ram_q)
   );

   assign iw_in = overlap(box_ff.left, box_ff.right, ram_q.left, ram_q.right);
   assign ih_in = overlap(box_ff.top, box_ff.bottom, ram_q.top, ram_q.bottom);
   assign inter3_in = 30'(iw_ff) * 30'(ih_ff);
   assign uni4_in = 31'(box_ff.area) + 31'(karea3_ff) - 31'(inter3_ff);
   assign prod5_in = 40'(threshold_ff) * 40'(uni4_ff);
   assign hit = valid_ff[PipeDepth-1] && (40'(lhs5_ff) > prod5_ff);

   always_comb begin
      kept_count_in = kept_count_ff;
      box_counter_in = box_counter_ff;
      rsp_payload_in.keep = keep_ff;
      rsp_payload_in.box_index = box_counter_ff;
      rsp_payload_in.store_overflow = keep_ff && store_full;
      rsp_payload_in.frame_end = last_ff;
      if (last_ff) begin
         kept_count_in = '0;
         box_counter_in = '0;
      end else begin
         if (store_wr) begin
            kept_count_in = kept_count_ff + 1'b1;
         end
         if (box_counter_ff < BoxIndexWidth'(IndexLimit)) begin
            box_counter_in = box_counter_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= ThresholdReset;
         kept_count_ff <= '0;
         box_counter_ff <= '0;
         valid_ff <= '0;
         rsp_valid_ff <= 1'b0;
         keep_ff <= 1'b1;
         rd_idx_ff <= '0;
      end else begin
         if (csr_write_enable) begin
            threshold_ff <= csr_write_data;
         end
         valid_ff <= {valid_ff[PipeDepth-2:0], cmd.issue};
         if (cmd.capture) begin
            rd_idx_ff <= '0;
         end else if (cmd.issue) begin
            rd_idx_ff <= rd_idx_ff + 1'b1;
         end
         if (cmd.capture) begin
            keep_ff <= 1'b1;
         end else if (hit) begin
            keep_ff <= 1'b0;
         end
         if (cmd.finish) begin
            kept_count_ff <= kept_count_in;
            box_counter_ff <= box_counter_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         box_ff <= box_in;
         last_ff <= req_payload.last_box;
      end
      iw_ff <= iw_in;
      ih_ff <= ih_in;
      karea2_ff <= ram_q.area;
      inter3_ff <= inter3_in;
      karea3_ff <= karea2_ff;
      uni4_ff <= uni4_in;
      inter4_ff <= inter3_ff;
      prod5_ff <= prod5_in;
      lhs5_ff <= {inter4_ff, 8'h00};
      if (cmd.finish) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   assign status.scan_done = (rd_idx_ff >= kept_count_ff);
   assign status.pipe_busy = |valid_ff;
   assign status.slot_free = !rsp_valid_ff || rsp_ready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   `ASSERT_IMPLIES(a_issue_in_range, clock, reset, cmd.issue, !status.scan_done)
   `ASSERT_IMPLIES(a_finish_drained, clock, reset, cmd.finish, !status.pipe_busy)
   `ASSERT_IMPLIES(a_count_bound, clock, reset, 1'b1, kept_count_ff <= CountWidth'(MAX_KEPT))
   `ASSERT_NEXT(a_frame_clear, clock, reset, cmd.finish && last_ff, kept_count_ff == '0)

endmodule

// ===== tb/tb_box_nms_suppressor_unit.sv =====
`timescale 1ns / 1ps

module tb_box_nms_suppressor_unit;
   import bnms_pkg::*;

   localparam int KeptDepth = 64;
   localparam int BoxLimit = 1024;
   localparam int IndexCeiling = (BoxLimit - 1 > IndexFieldMax) ? IndexFieldMax : BoxLimit - 1;
   localparam int StuckLimit = 20000;
   localparam int SettleCycles = 100;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   req_payload_type           req_payload = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   rsp_payload_type           rsp_payload;
   logic                      csr_write_enable = 1'b0;
   logic [ThresholdWidth-1:0] csr_write_data = '0;

   longint            kept_l[KeptDepth];
   longint            kept_t[KeptDepth];
   longint            kept_r[KeptDepth];
   longint            kept_b[KeptDepth];
   longint            kept_a[KeptDepth];
   int                kept_total;
   int                frame_pos;
   int                model_threshold;
   rsp_payload_type   pending_verdicts[$];

   int  mismatch_count = 0;
   int  boxes_accepted = 0;
   int  verdicts_checked = 0;
   int  kept_seen = 0;
   int  suppressed_seen = 0;
   int  overflow_seen = 0;
   int  frames_seen = 0;
   int  threshold_writes = 0;
   int  stuck_cycles = 0;
   int  hold_request = 0;
   int  stall_left = 0;
   bit  rsp_stall_on = 1'b1;
   bit  req_gaps_on = 1'b1;

   box_nms_suppressor_unit #(
      .MAX_KEPT(KeptDepth),
      .MAX_BOXES(BoxLimit)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_payload(req_payload),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_payload(rsp_payload),
      .csr_write_enable(csr_write_enable),
      .csr_write_data(csr_write_data)
   );

   always #6 clock = ~clock;

   function automatic longint span_overlap(longint a0, longint a1, longint b0, longint b1);
      longint lo;
      longint hi;
      lo = (a0 > b0) ? a0 : b0;
      hi = (a1 < b1) ? a1 : b1;
      return (hi > lo) ? hi - lo : 0;
   endfunction

   function automatic rsp_payload_type predict_verdict(input req_payload_type p);
      rsp_payload_type verdict;
      longint l, t, r, b, area, inter, uni;
      bit survives;
      l = longint'($signed(p.box_left));
      t = longint'($signed(p.box_top));
      r = l + longint'(p.box_width);
      b = t + longint'(p.box_height);
      area = longint'(p.box_width) * longint'(p.box_height);
      survives = 1'b1;
      for (int i = 0; i < kept_total; i++) begin
         inter = span_overlap(l, r, kept_l[i], kept_r[i]) *
                 span_overlap(t, b, kept_t[i], kept_b[i]);
         uni = area + kept_a[i] - inter;
         if (inter * 256 > longint'(model_threshold) * uni) begin
            survives = 1'b0;
         end
      end
      verdict = '0;
      verdict.keep = survives;
      verdict.box_index = frame_pos[BoxIndexWidth-1:0];
      verdict.frame_end = p.last_box;
      if (survives) begin
         if (kept_total < KeptDepth) begin
            kept_l[kept_total] = l;
            kept_t[kept_total] = t;
            kept_r[kept_total] = r;
            kept_b[kept_total] = b;
            kept_a[kept_total] = area;
            kept_total++;
         end else begin
            verdict.store_overflow = 1'b1;
         end
      end
      if (p.last_box) begin
         kept_total = 0;
         frame_pos = 0;
      end else if (frame_pos < IndexCeiling) begin
         frame_pos++;
      end
      return verdict;
   endfunction

   task automatic compare_field(input string name, input logic [15:0] want, input logic [15:0] got);
      if (got !== want) begin
         mismatch_count++;
         $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      end
   endtask

   task automatic check_verdict(input rsp_payload_type got);
      rsp_payload_type want;
      verdicts_checked++;
      if (got.keep === 1'b1) kept_seen++;
      if (got.keep === 1'b0) suppressed_seen++;
      if (got.store_overflow === 1'b1) overflow_seen++;
      if (got.frame_end === 1'b1) frames_seen++;
      if (pending_verdicts.size() == 0) begin
         mismatch_count++;
         $display("%0t: unexpected result, expected none actual %p", $time, got);
      end else begin
         want = pending_verdicts.pop_front();
         compare_field("keep", 16'(want.keep), 16'(got.keep));
         compare_field("box_index", 16'(want.box_index), 16'(got.box_index));
         compare_field("store_overflow", 16'(want.store_overflow), 16'(got.store_overflow));
         compare_field("frame_end", 16'(want.frame_end), 16'(got.frame_end));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         kept_total = 0;
         frame_pos = 0;
         model_threshold = ThresholdReset;
      end else begin
         if (csr_write_enable) model_threshold = csr_write_data;
         if (req_valid && req_ready) begin
            pending_verdicts.insert(pending_verdicts.size(), predict_verdict(req_payload));
            boxes_accepted++;
         end
         if (rsp_valid && rsp_ready) check_verdict(rsp_payload);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stuck_cycles <= 0;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
      if (stuck_cycles >= StuckLimit) begin
         $display("%0t: no transaction for %0d cycles", $time, StuckLimit);
         $display("tb_box_nms_suppressor_unit: errors");
         $finish;
      end
   end

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   always @(negedge clock) begin
      if (hold_request > 0) begin
         stall_left = hold_request;
         hold_request = 0;
      end
      if ($urandom_range(0, 299) == 0) rsp_stall_on = !rsp_stall_on;
      if (stall_left == 0 && rsp_stall_on && $urandom_range(0, 3) == 0) stall_left = pick_gap();
      if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left--;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   function automatic req_payload_type make_box(input int l, input int t, input int w, input int h,
                                                input bit last);
      req_payload_type p;
      p.box_left = l[15:0];
      p.box_top = t[15:0];
      p.box_width = w[14:0];
      p.box_height = h[14:0];
      p.last_box = last;
      return p;
   endfunction

   function automatic req_payload_type noise_box(input bit last);
      req_payload_type p;
      p.box_left = 16'($urandom);
      p.box_top = 16'($urandom);
      p.box_width = 15'($urandom);
      p.box_height = 15'($urandom);
      p.last_box = last;
      return p;
   endfunction

   function automatic req_payload_type cluster_box(input int cx, input int cy, input int jitter,
                                                   input int max_size, input bit last);
      int l;
      int t;
      l = cx + int'($urandom_range(0, 2 * jitter)) - jitter;
      t = cy + int'($urandom_range(0, 2 * jitter)) - jitter;
      l = (l > 32767) ? 32767 : ((l < -32768) ? -32768 : l);
      t = (t > 32767) ? 32767 : ((t < -32768) ? -32768 : t);
      return make_box(l, t, $urandom_range(0, max_size), $urandom_range(0, max_size), last);
   endfunction

   task automatic send_box(input req_payload_type p);
      req_valid <= 1'b1;
      req_payload <= p;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic offer_box(input req_payload_type p);
      int gap;
      send_box(p);
      gap = req_gaps_on ? pick_gap() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending_verdicts.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_threshold(input int value);
      wait_drained();
      csr_write_enable <= 1'b1;
      csr_write_data <= value[ThresholdWidth-1:0];
      @(negedge clock);
      csr_write_enable <= 1'b0;
      threshold_writes++;
      @(negedge clock);
   endtask

   task automatic test_directed_cases();
      // reset threshold: duplicate, partial overlap, disjoint, edge contact, extremes
      offer_box(make_box(0, 0, 160, 160, 0));
      offer_box(make_box(0, 0, 160, 160, 0));
      offer_box(make_box(80, 0, 160, 160, 0));
      offer_box(make_box(2000, 2000, 160, 160, 0));
      offer_box(make_box(160, 0, 160, 160, 0));
      offer_box(make_box(-32768, -32768, 32767, 32767, 0));
      offer_box(make_box(32767, 32767, 32767, 32767, 1));
      // zero union
      offer_box(make_box(5, 5, 0, 0, 0));
      offer_box(make_box(5, 5, 0, 0, 0));
      offer_box(make_box(0, 0, 32767, 0, 1));
      write_threshold(0);
      offer_box(make_box(0, 0, 16, 16, 0));
      offer_box(make_box(15, 15, 16, 16, 0));
      offer_box(make_box(16, 0, 16, 16, 1));
      write_threshold(256);
      offer_box(make_box(0, 0, 32767, 32767, 0));
      offer_box(make_box(0, 0, 32767, 32767, 0));
      offer_box(make_box(1, 0, 32767, 32767, 1));
      write_threshold(511);
      offer_box(make_box(-100, -100, 50, 50, 0));
      offer_box(make_box(-100, -100, 50, 50, 1));
   endtask

   task automatic test_store_full();
      write_threshold(0);
      offer_box(make_box(0, 0, 16, 16, 0));
      for (int i = 0; i < KeptDepth + 5; i++) begin
         offer_box(make_box(int'($urandom_range(0, 60000)) - 30000,
                            int'($urandom_range(0, 60000)) - 30000, 0, 0, 0));
      end
      offer_box(make_box(0, 0, 16, 16, 0));
      offer_box(make_box(5000, 5000, 64, 64, 0));
      offer_box(make_box(5000, 5000, 64, 64, 1));
   endtask

   task automatic test_index_saturation();
      write_threshold(128);
      for (int i = 0; i < IndexCeiling + 17; i++) begin
         offer_box(cluster_box(0, 0, 12000, 200, i == IndexCeiling + 16));
      end
   endtask

   task automatic run_random_frame(output int len);
      int cx[3];
      int cy[3];
      int jitter;
      int max_size;
      int k;
      bit last;
      req_gaps_on = ($urandom_range(0, 3) != 0);
      k = $urandom_range(0, 99);
      len = (k < 80) ? $urandom_range(1, 12) : ((k < 95) ? $urandom_range(13, 40)
                                                         : $urandom_range(KeptDepth + 1, 80));
      for (int c = 0; c < 3; c++) begin
         cx[c] = int'($urandom_range(0, 40000)) - 20000;
         cy[c] = int'($urandom_range(0, 40000)) - 20000;
      end
      case ($urandom_range(0, 2))
         0: jitter = 32;
         1: jitter = 200;
         default: jitter = 2000;
      endcase
      max_size = $urandom_range(0, 1) ? 64 : 400;
      if (len > KeptDepth) begin
         jitter = 12000;
         max_size = 40;
      end
      for (int i = 0; i < len; i++) begin
         last = (i == len - 1);
         k = $urandom_range(0, 2);
         if ($urandom_range(0, 99) < 8) begin
            offer_box(noise_box(last || $urandom_range(0, 29) == 0));
         end else begin
            offer_box(cluster_box(cx[k], cy[k], jitter, max_size, last));
         end
      end
   endtask

   task automatic test_random_frames();
      int thr;
      int sent;
      int len;
      for (int phase = 0; phase < 8; phase++) begin
         case (phase)
            0: thr = 128;
            1: thr = 0;
            2: thr = 256;
            3: thr = 511;
            default: thr = $urandom_range(0, 511);
         endcase
         write_threshold(thr);
         sent = 0;
         while (sent < 110) begin
            run_random_frame(len);
            sent += len;
         end
      end
      req_gaps_on = 1'b1;
   endtask

   task automatic test_backpressure();
      write_threshold(128);
      req_gaps_on = 1'b0;
      hold_request = 1500;
      for (int i = 0; i < 40; i++) begin
         send_box(cluster_box(100, 100, 200, 300, i == 39));
      end
      wait_drained();
      req_gaps_on = 1'b1;
      for (int i = 0; i < 10; i++) begin
         offer_box(cluster_box(-500, 700, 100, 300, i == 9));
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_directed_cases();
      test_store_full();
      test_index_saturation();
      test_random_frames();
      test_backpressure();
      wait_drained();
      repeat (SettleCycles) @(posedge clock);
      if (pending_verdicts.size() != 0) begin
         mismatch_count++;
         $display("%0t: %0d results never arrived", $time, pending_verdicts.size());
      end
      $display("covered %0d boxes in %0d frames under %0d threshold settings",
               boxes_accepted, frames_seen, threshold_writes + 1);
      $display("checked %0d results: %0d kept, %0d suppressed, %0d kept with full store",
               verdicts_checked, kept_seen, suppressed_seen, overflow_seen);
      if (mismatch_count == 0) begin
         $display("tb_box_nms_suppressor_unit: clean");
      end else begin
         $display("tb_box_nms_suppressor_unit: errors");
      end
      $finish;
   end

endmodule

// ===== box_nms_suppressor_unit.f =====
+incdir+src
src/bnms_pkg.sv
src/bnms_ram.sv
src/bnms_ctrl.sv
src/bnms_datapath.sv
src/box_nms_suppressor_unit.sv
tb/tb_box_nms_suppressor_unit.sv
